### rtl/serial_command_frame_parser_unit_defines.svh
// assertion macros for the serial command frame parser
`ifndef SERIAL_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

// clocked assertion with a generic message, disabled during reset
`define SCFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scfp assertion failed");

// clocked assertion with a caller supplied message
`define SCFP_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

### rtl/scfp_pkg.sv
`timescale 1ns / 1ps
package scfp_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_COMMIT  = 3'd1,
    KIND_ABORT   = 3'd2,
    KIND_REPLY   = 3'd3,
    KIND_POWER   = 3'd4
  } kind_e;

  // configuration register indexes
  localparam logic [2:0] CFG_DELIMITER = 3'd0;
  localparam logic [2:0] CFG_CODE_TX   = 3'd1;
  localparam logic [2:0] CFG_CODE_GET  = 3'd2;
  localparam logic [2:0] CFG_CODE_SET  = 3'd3;
  localparam logic [2:0] CFG_CODE_RET  = 3'd4;
  localparam logic [2:0] CFG_PARA      = 3'd5;
  localparam logic [2:0] CFG_OWN_ADDR  = 3'd6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration reset values
  localparam logic [7:0]  RST_DELIMITER = 8'h7e;
  localparam logic [7:0]  RST_CODE_TX   = 8'h01;
  localparam logic [7:0]  RST_CODE_GET  = 8'h02;
  localparam logic [7:0]  RST_CODE_SET  = 8'h03;
  localparam logic [7:0]  RST_CODE_RET  = 8'h04;
  localparam logic [23:0] RST_PARA      = 24'h030201;
  localparam logic [15:0] RST_OWN_ADDR  = 16'h0000;

  localparam logic [7:0] GOOD_SUM     = 8'hff;
  localparam logic [7:0] REPLY_LEN    = 8'd4;
  // type and destination overhead counted in the length of a data frame
  localparam logic [7:0] DATA_HDR_LEN = 8'd3;

  // reply run layout
  localparam int unsigned REPLY_BYTES = 7;
  localparam int unsigned REPLY_CNT_W = $clog2(REPLY_BYTES);
  localparam logic [REPLY_CNT_W-1:0] RB_DELIM = REPLY_CNT_W'(0);
  localparam logic [REPLY_CNT_W-1:0] RB_LEN   = REPLY_CNT_W'(1);
  localparam logic [REPLY_CNT_W-1:0] RB_RET   = REPLY_CNT_W'(2);
  localparam logic [REPLY_CNT_W-1:0] RB_SEL   = REPLY_CNT_W'(3);
  localparam logic [REPLY_CNT_W-1:0] RB_LO    = REPLY_CNT_W'(4);
  localparam logic [REPLY_CNT_W-1:0] RB_HI    = REPLY_CNT_W'(5);
  localparam logic [REPLY_CNT_W-1:0] RB_CK    = REPLY_CNT_W'(REPLY_BYTES - 1);

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] ret;
    logic [7:0] sel;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] ck;
  } reply_t;

  // what one accepted item hands to the output side
  typedef struct packed {
    logic        emit;
    logic        reply;
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] dest;
    reply_t      rep;
  } desc_t;

endpackage

### rtl/scfp_parser.sv
`timescale 1ns / 1ps
module scfp_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            step_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            queue_full_i,
  input  logic [7:0]                      link_rssi_i,
  output scfp_pkg::desc_t                 desc_o
);
  import scfp_pkg::*;

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_LEN  = 4'd1;
  localparam logic [3:0] PH_TYPE = 4'd2;
  localparam logic [3:0] PH_DLO  = 4'd3;
  localparam logic [3:0] PH_DHI  = 4'd4;
  localparam logic [3:0] PH_PAY  = 4'd5;
  localparam logic [3:0] PH_DCK  = 4'd6;
  localparam logic [3:0] PH_SKIP = 4'd7;
  localparam logic [3:0] PH_GSEL = 4'd8;
  localparam logic [3:0] PH_GLO  = 4'd9;
  localparam logic [3:0] PH_GHI  = 4'd10;
  localparam logic [3:0] PH_GCK  = 4'd11;
  localparam logic [3:0] PH_SSEL = 4'd12;
  localparam logic [3:0] PH_SLO  = 4'd13;
  localparam logic [3:0] PH_SHI  = 4'd14;
  localparam logic [3:0] PH_SCK  = 4'd15;

  logic [7:0]  delim_q, code_tx_q, code_get_q, code_set_q, code_ret_q;
  logic [23:0] para_q;
  logic [15:0] own_addr_q;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] dest_q, dest_d;
  logic [7:0]  sel_q, sel_d;
  logic [7:0]  value_lo_q, value_lo_d;
  logic [7:0]  tx_power_q, tx_power_d;

  logic [7:0] sum_add;
  logic [7:0] c_tx, c_addr, c_rssi;
  logic [7:0] rep_lo, rep_hi, rep_ck;
  logic [7:0] len_left;

  assign c_tx     = para_q[7:0];
  assign c_addr   = para_q[15:8];
  assign c_rssi   = para_q[23:16];
  assign sum_add  = sum_q + rx_byte_i;
  assign len_left = frame_len_q - DATA_HDR_LEN;

  // parameter value for a query, tx power first in a code clash
  always_comb begin
    rep_lo = 8'h00;
    rep_hi = 8'h00;
    priority if (sel_q == c_tx) begin
      rep_lo = tx_power_q;
    end else if (sel_q == c_addr) begin
      rep_lo = own_addr_q[7:0];
      rep_hi = own_addr_q[15:8];
    end else if (sel_q == c_rssi) begin
      rep_lo = link_rssi_i;
    end else begin
      // unknown parameter reads as zero
      rep_lo = 8'h00;
      rep_hi = 8'h00;
    end
  end

  assign rep_ck = GOOD_SUM - REPLY_LEN - code_ret_q - sel_q - rep_lo - rep_hi;

  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    left_d      = left_q;
    sum_d       = sum_q;
    dest_d      = dest_q;
    sel_d       = sel_q;
    value_lo_d  = value_lo_q;
    tx_power_d  = tx_power_q;
    desc_o       = '0;
    desc_o.kind  = KIND_PAYLOAD;
    desc_o.rep   = '{delim: delim_q, ret: code_ret_q, sel: sel_q,
                     lo: rep_lo, hi: rep_hi, ck: rep_ck};
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == delim_q) phase_d = PH_LEN;
        end
        PH_LEN: begin
          // zero length drops the frame
          if (rx_byte_i == 8'h00) begin
            phase_d = PH_HUNT;
          end else begin
            frame_len_d = rx_byte_i;
            sum_d       = rx_byte_i;
            phase_d     = PH_TYPE;
          end
        end
        PH_TYPE: begin
          sum_d = sum_add;
          priority if (rx_byte_i == code_tx_q) begin
            phase_d = (frame_len_q < DATA_HDR_LEN) ? PH_HUNT : PH_DLO;
          end else if (rx_byte_i == code_get_q) begin
            phase_d = PH_GSEL;
          end else if (rx_byte_i == code_set_q) begin
            phase_d = PH_SSEL;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DLO: begin
          sum_d   = sum_add;
          dest_d  = {8'h00, rx_byte_i};
          phase_d = PH_DHI;
        end
        PH_DHI: begin
          sum_d  = sum_add;
          dest_d = {rx_byte_i, dest_q[7:0]};
          left_d = len_left;
          priority if (queue_full_i) begin
            phase_d = PH_SKIP;
          end else if (len_left == 8'h00) begin
            phase_d = PH_DCK;
          end else begin
            phase_d = PH_PAY;
          end
        end
        PH_PAY: begin
          sum_d       = sum_add;
          desc_o.emit = 1'b1;
          desc_o.kind = KIND_PAYLOAD;
          desc_o.data = rx_byte_i;
          desc_o.dest = dest_q;
          left_d      = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_DCK;
        end
        PH_DCK: begin
          sum_d       = sum_add;
          desc_o.emit = 1'b1;
          desc_o.kind = (sum_add == GOOD_SUM) ? KIND_COMMIT : KIND_ABORT;
          desc_o.dest = dest_q;
          phase_d     = PH_HUNT;
        end
        PH_SKIP: begin
          // payload and checksum pass silently
          if (left_q == 8'h00) begin
            phase_d = PH_HUNT;
          end else begin
            left_d = left_q - 8'd1;
          end
        end
        PH_GSEL: begin
          sum_d   = sum_add;
          sel_d   = rx_byte_i;
          phase_d = PH_GLO;
        end
        PH_SSEL: begin
          sum_d   = sum_add;
          sel_d   = rx_byte_i;
          phase_d = PH_SLO;
        end
        PH_GLO: begin
          sum_d      = sum_add;
          value_lo_d = rx_byte_i;
          phase_d    = PH_GHI;
        end
        PH_SLO: begin
          sum_d      = sum_add;
          value_lo_d = rx_byte_i;
          phase_d    = PH_SHI;
        end
        PH_GHI: begin
          sum_d   = sum_add;
          phase_d = PH_GCK;
        end
        PH_SHI: begin
          sum_d   = sum_add;
          phase_d = PH_SCK;
        end
        PH_GCK: begin
          sum_d = sum_add;
          if (sum_add == GOOD_SUM) begin
            desc_o.emit  = 1'b1;
            desc_o.reply = 1'b1;
            desc_o.kind  = KIND_REPLY;
          end
          phase_d = PH_HUNT;
        end
        PH_SCK: begin
          sum_d = sum_add;
          if (sum_add == GOOD_SUM && sel_q == c_tx) begin
            tx_power_d  = value_lo_q;
            desc_o.emit = 1'b1;
            desc_o.kind = KIND_POWER;
            desc_o.data = value_lo_q;
          end
          phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= 8'h00;
      left_q      <= 8'h00;
      sum_q       <= 8'h00;
      dest_q      <= 16'h0000;
      sel_q       <= 8'h00;
      value_lo_q  <= 8'h00;
      tx_power_q  <= 8'h00;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      left_q      <= left_d;
      sum_q       <= sum_d;
      dest_q      <= dest_d;
      sel_q       <= sel_d;
      value_lo_q  <= value_lo_d;
      tx_power_q  <= tx_power_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= RST_DELIMITER;
      code_tx_q  <= RST_CODE_TX;
      code_get_q <= RST_CODE_GET;
      code_set_q <= RST_CODE_SET;
      code_ret_q <= RST_CODE_RET;
      para_q     <= RST_PARA;
      own_addr_q <= RST_OWN_ADDR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DELIMITER: delim_q    <= cfg_data_i[7:0];
        CFG_CODE_TX:   code_tx_q  <= cfg_data_i[7:0];
        CFG_CODE_GET:  code_get_q <= cfg_data_i[7:0];
        CFG_CODE_SET:  code_set_q <= cfg_data_i[7:0];
        CFG_CODE_RET:  code_ret_q <= cfg_data_i[7:0];
        CFG_PARA:      para_q     <= cfg_data_i;
        CFG_OWN_ADDR:  own_addr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/scfp_emitter.sv
`timescale 1ns / 1ps
module scfp_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  scfp_pkg::desc_t desc_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     dest_addr_o,
  output logic            last_o
);
  import scfp_pkg::*;

  logic                   valid_q;
  logic                   reply_q;
  logic [REPLY_CNT_W-1:0] cnt_q;
  kind_e                  kind_q;
  logic [7:0]             data_q;
  logic [15:0]            dest_q;
  reply_t                 rep_q;

  logic take;
  logic run_done;

  assign take       = valid_q & out_ready_i;
  assign run_done   = !reply_q || (cnt_q == RB_CK);
  assign can_load_o = !valid_q || (out_ready_i && run_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      reply_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      reply_q <= desc_i.reply;
      cnt_q   <= '0;
    end else if (take) begin
      if (run_done) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + REPLY_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= desc_i.kind;
      data_q <= desc_i.data;
      dest_q <= desc_i.dest;
      rep_q  <= desc_i.rep;
    end
  end

  always_comb begin
    out_byte_o = data_q;
    if (reply_q) begin
      unique case (cnt_q)
        RB_DELIM: out_byte_o = rep_q.delim;
        RB_LEN:   out_byte_o = REPLY_LEN;
        RB_RET:   out_byte_o = rep_q.ret;
        RB_SEL:   out_byte_o = rep_q.sel;
        RB_LO:    out_byte_o = rep_q.lo;
        RB_HI:    out_byte_o = rep_q.hi;
        RB_CK:    out_byte_o = rep_q.ck;
        default:  out_byte_o = 8'h00;
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign dest_addr_o = dest_q;
  assign last_o      = reply_q && (cnt_q == RB_CK);

endmodule

### rtl/serial_command_frame_parser_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o   rx_byte_i, queue_full_i, link_rssi_i
// out       output     out_valid_o/out_ready_i out_kind_o, out_byte_o, dest_addr_o, last_o
// cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// one received byte is taken per cycle while in_ready_o is high, advancing the frame state
// an item causing one result shows it on the output register the next cycle
// a good parameter query gives a seven byte reply run; input is held off until the
//   last reply byte is taken
// a result waiting on a stalled output holds input off; the input is taken again in
//   the cycle the last pending result leaves
// rst_ni clears the frame state and the output valid flag and sets the registers to their defaults
module serial_command_frame_parser_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // receive byte stream
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            queue_full_i,
  input  logic [7:0]                      link_rssi_i,
  // result stream
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      out_kind_o,
  output logic [7:0]                      out_byte_o,
  output logic [15:0]                     dest_addr_o,
  output logic                            last_o,
  // register writes
  input  logic                            cfg_we_i,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scfp_pkg::*;

  logic  step;
  logic  can_load;
  desc_t desc;

  // a byte is parsed only when the output side can take what it causes
  assign in_ready_o = can_load;
  assign step       = in_valid_i & can_load;

  // frame state machine and register file
  scfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .step_i       (step),
    .rx_byte_i    (rx_byte_i),
    .queue_full_i (queue_full_i),
    .link_rssi_i  (link_rssi_i),
    .desc_o       (desc)
  );

  // result register with reply run sequencer
  scfp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step & desc.emit),
    .desc_i      (desc),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .dest_addr_o (dest_addr_o),
    .last_o      (last_o)
  );

endmodule

### rtl/scfp_checker.sv
`timescale 1ns / 1ps
`include "serial_command_frame_parser_unit_defines.svh"
module scfp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [7:0]                      rx_byte_i,
  input logic                            queue_full_i,
  input logic [7:0]                      link_rssi_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [2:0]                      out_kind_o,
  input logic [7:0]                      out_byte_o,
  input logic [15:0]                     dest_addr_o,
  input logic                            last_o,
  input logic                            cfg_we_i,
  input logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scfp_pkg::*;

  logic mid_reply;
  assign mid_reply = out_valid_o && (out_kind_o == KIND_REPLY) && !last_o;

  // last only closes a reply run
  `SCFP_ASSERT_MSG(a_last_reply, clk_i, rst_ni, out_valid_o && last_o |-> out_kind_o == KIND_REPLY, "last outside a reply run")
  // nothing is taken in while a reply run is unfinished
  `SCFP_ASSERT_MSG(a_reply_blocks, clk_i, rst_ni, mid_reply |-> !in_ready_o, "input taken during a reply run")
  // a reply run continues without gaps or interleaved results
  `SCFP_ASSERT(a_reply_cont, clk_i, rst_ni, mid_reply && out_ready_i |=> out_valid_o && out_kind_o == KIND_REPLY)
  // a stalled result stays offered
  `SCFP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o) && $stable(out_byte_o))

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (.*);
